FILE: rtl/mcu_pkg.sv
// Shared constants, types and codes for the MSB-first code unpacker.
`timescale 1ns / 1ps
package mcu_pkg;

	localparam int MAX_CODE_BITS = 32;
	localparam int OUT_CODE_BITS = 32;
	localparam int WIDTH_LIMIT   = (MAX_CODE_BITS < OUT_CODE_BITS) ? MAX_CODE_BITS
	                                                               : OUT_CODE_BITS;
	localparam int WIN_BITS      = 40;
	localparam int BYTE_BITS     = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int CW_W          = 6;
	localparam int VB_W          = 6;
	localparam int CNT_W         = $clog2(MAX_RESULTS);
	localparam int CMDQ_DEPTH    = 2;
	localparam int CMDQ_AW       = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW       = $clog2(CMDQ_DEPTH + 1);

	localparam logic MODE_PUSH  = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                 mode;
		logic [BYTE_BITS-1:0] data_byte;
		logic [CW_W-1:0]      code_width;
	} cmd_t;

	typedef struct packed {
		logic [OUT_CODE_BITS-1:0] code_value;
		logic                     last_of_run;
	} res_t;

	typedef struct packed {
		logic            emit;
		logic [VB_W-1:0] vbits;
		logic [CW_W-1:0] width;
	} stat_t;

endpackage

FILE: rtl/mcu_front.sv
// Front end: accepts requests, drops those with an illegal width, queues the rest.
`timescale 1ns / 1ps
module mcu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  mcu_pkg::cmd_t in_cmd,
	output logic          cmd_valid,
	output mcu_pkg::cmd_t cmd,
	input  logic          cmd_take
);
	import mcu_pkg::*;

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] cnt_q;
	logic               accept;
	logic               width_ok;
	logic               enq;
	logic               deq;

	assign full      = (cnt_q == CMDQ_CW'(CMDQ_DEPTH));
	assign accept    = push && !full;
	assign width_ok  = (in_cmd.code_width != '0) &&
	                   (in_cmd.code_width <= CW_W'(WIDTH_LIMIT));
	assign enq       = accept && width_ok;
	assign cmd_valid = (cnt_q != '0);
	assign deq       = cmd_take && cmd_valid;
	assign cmd       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/mcu_back.sv
// Back end: bit window, byte append and one code extraction per cycle while the result register can take it.
`timescale 1ns / 1ps
module mcu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  mcu_pkg::cmd_t  cmd,
	output logic           cmd_take,
	input  logic           res_ready,
	output logic           res_valid,
	output mcu_pkg::res_t  res,
	output mcu_pkg::stat_t stat
);
	import mcu_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic [WIN_BITS-1:0] win_q;
	logic [VB_W-1:0]     vbits_q;
	logic [CW_W-1:0]     width_q;
	logic                drain_q;
	logic [CNT_W-1:0]    cnt_q;

	logic                load;
	logic                emit;
	logic                can;
	logic                last;
	logic                room;
	logic [VB_W-1:0]     rem;
	logic [CW_W-1:0]     sh_full;
	logic [WIN_BITS-1:0] win_app;

	assign can     = (vbits_q >= VB_W'(width_q));
	assign rem     = vbits_q - VB_W'(width_q);
	assign last    = drain_q || (cnt_q == CNT_W'(MAX_RESULTS - 1)) ||
	                 (rem < VB_W'(width_q));
	assign room    = (vbits_q <= VB_W'(WIN_BITS - BYTE_BITS));
	// new byte lands just below the held bits
	assign win_app = win_q | (WIN_BITS'(cmd.data_byte) <<
	                 (VB_W'(WIN_BITS - BYTE_BITS) - vbits_q));
	assign sh_full = CW_W'(OUT_CODE_BITS) - width_q;

	assign res.code_value  = win_q[WIN_BITS-1 -: OUT_CODE_BITS] >> sh_full;
	assign res.last_of_run = last;
	assign res_valid       = emit;

	assign stat.emit  = emit;
	assign stat.vbits = vbits_q;
	assign stat.width = width_q;

	always_comb begin
		state_d  = state_q;
		cmd_take = 1'b0;
		load     = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					load     = 1'b1;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!can) begin
					state_d = ST_IDLE;
				end else if (res_ready) begin
					emit = 1'b1;
					if (last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			vbits_q <= '0;
			width_q <= '0;
			drain_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			width_q <= cmd.code_width;
			drain_q <= (cmd.mode == MODE_DRAIN);
			cnt_q   <= '0;
			if ((cmd.mode == MODE_PUSH) && room) begin
				win_q   <= win_app;
				vbits_q <= vbits_q + VB_W'(BYTE_BITS);
			end
		end else if (emit) begin
			win_q   <= win_q << width_q;
			vbits_q <= rem;
			cnt_q   <= cnt_q + 1'b1;
		end
	end

endmodule

FILE: rtl/mcu_outq.sv
// Result holding register presented as a one-entry queue.
`timescale 1ns / 1ps
module mcu_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  mcu_pkg::res_t res,
	output logic          res_ready,
	output logic          empty,
	input  logic          pop,
	output mcu_pkg::res_t head
);
	import mcu_pkg::*;

	logic valid_q;
	res_t data_q;

	assign empty     = !valid_q;
	assign res_ready = !valid_q || pop;
	assign head      = data_q;

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/msb_first_code_unpacker.sv
// Top level of the MSB-first variable-width code unpacker.
//
//   channel  | handshake         | payload
//   ---------+-------------------+----------------------------------
//   request  | push / full       | mode, data_byte, code_width
//   result   | empty / pop       | code_value, last_of_run
//
// In the back end a request is first loaded, then its codes are extracted one per
// cycle while results are taken, up to eight per request, before the next request.
// A two-entry request queue separates front and back; a one-entry result
// register stalls the back end while a result waits for pop.
// Reset clears the window, queues and state machine; no clearing pass.
`timescale 1ns / 1ps
module msb_first_code_unpacker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              mode,
	input  logic [mcu_pkg::BYTE_BITS-1:0]     data_byte,
	input  logic [mcu_pkg::CW_W-1:0]          code_width,
	output logic                              empty,
	input  logic                              pop,
	output logic [mcu_pkg::OUT_CODE_BITS-1:0] code_value,
	output logic                              last_of_run
);
	import mcu_pkg::*;

	cmd_t  in_cmd;
	cmd_t  cmd;
	logic  cmd_valid;
	logic  cmd_take;
	res_t  res;
	logic  res_valid;
	logic  res_ready;
	res_t  head;
	stat_t stat;

	assign in_cmd.mode       = mode;
	assign in_cmd.data_byte  = data_byte;
	assign in_cmd.code_width = code_width;

	mcu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_cmd    (in_cmd),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	mcu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res),
		.stat      (stat)
	);

	mcu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.empty     (empty),
		.pop       (pop),
		.head      (head)
	);

	assign code_value  = head.code_value;
	assign last_of_run = head.last_of_run;

	a_vbits_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.vbits <= VB_W'(WIN_BITS))
		else $error("held bit count beyond window");

	a_emit_enough_bits: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |-> (stat.vbits >= VB_W'(stat.width)) && (stat.width != '0))
		else $error("code taken with too few held bits");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |-> (empty || pop))
		else $error("result overwritten before pop");

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for msb_first_code_unpacker: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
	import mcu_pkg::*;

	localparam int RANDOM_ITEMS = 120;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 30;

	logic                     clk;
	logic                     arst_n;
	logic                     push;
	logic                     full;
	logic                     mode;
	logic [BYTE_BITS-1:0]     data_byte;
	logic [CW_W-1:0]          code_width;
	logic                     empty;
	logic                     pop;
	logic [OUT_CODE_BITS-1:0] code_value;
	logic                     last_of_run;

	// predictor state
	logic [WIN_BITS-1:0] win_bits = '0;
	int                  held_bits = 0;
	res_t                pending_codes[$];

	int err_count = 0;
	bit tx_no_idle = 0;
	bit rx_no_idle = 0;
	bit hold_off_req = 0;

	msb_first_code_unpacker DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.data_byte  (data_byte),
		.code_width (code_width),
		.empty      (empty),
		.pop        (pop),
		.code_value (code_value),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("mismatch at %0t: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
		err_count++;
	endtask

	function automatic res_t take_code(input logic [CW_W-1:0] w);
		res_t r;
		r.code_value  = 32'(win_bits >> (WIN_BITS - w));
		r.last_of_run = 1'b0;
		win_bits      = win_bits << w;
		held_bits     = held_bits - w;
		return r;
	endfunction

	function automatic void unpack_predict(input logic m, input logic [BYTE_BITS-1:0] b,
	                                       input logic [CW_W-1:0] w);
		res_t                codes[$];
		logic [WIN_BITS-1:0] ext;
		ext = WIN_BITS'(b);
		// out-of-range width: whole request ignored
		if (w == 0 || w > WIDTH_LIMIT)
			return;
		if (m == MODE_PUSH) begin
			// byte dropped when the window cannot take it
			if (held_bits + BYTE_BITS <= WIN_BITS) begin
				win_bits  = win_bits | (ext << (WIN_BITS - BYTE_BITS - held_bits));
				held_bits = held_bits + BYTE_BITS;
			end
			while (codes.size() < MAX_RESULTS && held_bits >= w)
				codes.push_back(take_code(w));
		end else if (held_bits >= w) begin
			codes.push_back(take_code(w));
		end
		if (codes.size() > 0)
			codes[codes.size() - 1].last_of_run = 1'b1;
		foreach (codes[i])
			pending_codes.push_back(codes[i]);
	endfunction

	// push stays high across back-to-back requests; dropped only before a gap
	task automatic send_item(input logic m, input logic [BYTE_BITS-1:0] b,
	                         input logic [CW_W-1:0] w);
		int gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			@(negedge clk) push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk) begin
			push       <= 1'b1;
			mode       <= m;
			data_byte  <= b;
			code_width <= w;
		end
		do @(posedge clk); while (full);
		unpack_predict(m, b, w);
	endtask

	// result side: pop with random gaps, plus one long hold-off on request
	initial begin
		int   gap;
		res_t want;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				@(negedge clk) pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 0;
			end
			gap = rx_no_idle ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				@(negedge clk) pop <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (pending_codes.size() == 0) begin
				report_mismatch("unexpected code", code_value, 32'h0);
			end else begin
				want = pending_codes.pop_front();
				if (code_value !== want.code_value)
					report_mismatch("code_value", code_value, want.code_value);
				if (last_of_run !== want.last_of_run)
					report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last_of_run));
			end
		end
	end

	// watchdog: too many cycles without any accepted transfer
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				stalled = 0;
			else
				stalled++;
		end
		$display("[msb_first_code_unpacker] ERROR");
		$finish;
	end

	task automatic test_basic_widths();
		send_item(MODE_PUSH, 8'h00, 6'd8);
		send_item(MODE_PUSH, 8'hFF, 6'd8);
		send_item(MODE_PUSH, 8'hA5, 6'd1);
		send_item(MODE_PUSH, 8'h3C, 6'd32);
		send_item(MODE_DRAIN, 8'h00, 6'd32);  // too few bits held
		send_item(MODE_DRAIN, 8'hFF, 6'd3);
		send_item(MODE_PUSH, 8'h5A, 6'd0);    // widths out of range: ignored
		send_item(MODE_PUSH, 8'h5A, 6'd33);
		send_item(MODE_PUSH, 8'hFF, 6'd63);
		send_item(MODE_DRAIN, 8'h00, 6'd0);
	endtask

	task automatic test_result_limit();
		send_item(MODE_PUSH, 8'h12, 6'd32);
		send_item(MODE_PUSH, 8'h34, 6'd32);
		send_item(MODE_PUSH, 8'h56, 6'd32);
		// more complete codes than one request may emit
		send_item(MODE_PUSH, 8'h78, 6'd1);
		send_item(MODE_PUSH, 8'h9A, 6'd1);
		send_item(MODE_DRAIN, 8'h00, 6'd1);
		send_item(MODE_DRAIN, 8'h00, 6'd28);
		repeat (4) send_item(MODE_PUSH, 8'hFF, 6'd32);
		send_item(MODE_PUSH, 8'hC3, 6'd2);
		send_item(MODE_PUSH, 8'h81, 6'd7);
		send_item(MODE_DRAIN, 8'h00, 6'd1);
	endtask

	task automatic test_random_stream();
		int               sent;
		int               seg_len;
		int               base_w;
		int               r;
		logic             m;
		logic [CW_W-1:0]  w;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r < 5)
				base_w = $urandom_range(9, 12);
			else if (r < 8)
				base_w = $urandom_range(1, 8);
			else
				base_w = $urandom_range(13, 32);
			seg_len    = $urandom_range(5, 30);
			tx_no_idle = ($urandom_range(0, 3) == 0);
			rx_no_idle = ($urandom_range(0, 3) == 0);
			repeat (seg_len) begin
				r = $urandom_range(0, 99);
				m = MODE_PUSH;
				w = CW_W'(base_w);
				if (r < 15)
					m = MODE_DRAIN;
				else if (r < 22)
					w = CW_W'($urandom_range(1, WIDTH_LIMIT));
				else if (r < 28)
					w = (r % 2 == 0) ? CW_W'(0) : CW_W'($urandom_range(WIDTH_LIMIT + 1, 63));
				else if (r >= 97 && base_w < WIDTH_LIMIT)
					base_w++;  // code width grows as the dictionary would
				send_item(m, BYTE_BITS'($urandom_range(0, 255)), w);
				if (w != 0 && w <= WIDTH_LIMIT)
					sent++;
			end
		end
		tx_no_idle = 0;
		rx_no_idle = 0;
	endtask

	task automatic test_backpressure();
		int k;
		tx_no_idle   = 1;
		hold_off_req = 1;
		for (k = 0; k < 40; k++)
			send_item(MODE_PUSH, BYTE_BITS'($urandom_range(0, 255)),
			          CW_W'($urandom_range(3, 5)));
		tx_no_idle = 0;
		@(negedge clk) push <= 1'b0;
		while (hold_off_req) @(posedge clk);
	endtask

	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		mode       = MODE_PUSH;
		data_byte  = '0;
		code_width = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_basic_widths();
		test_result_limit();
		test_random_stream();
		test_backpressure();
		test_random_stream();

		@(negedge clk) push <= 1'b0;
		while (pending_codes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("[msb_first_code_unpacker] OK");
		else
			$display("[msb_first_code_unpacker] ERROR");
		$finish;
	end

endmodule
